@@ rtl/core/qrs_pkg.sv @@
`timescale 1ns / 1ps

package qrs_pkg;

  // Coefficient format
  localparam int CoefWidth = 32;
  localparam int FracBits  = 16;

  // Derived widths
  localparam int MagW   = CoefWidth;            // magnitude of a coefficient
  localparam int ProdW  = 2 * CoefWidth;        // one product
  localparam int DiscW  = 2 * CoefWidth + 1;    // |b*b - 4ac|
  localparam int RootW  = (DiscW + 1) / 2;      // floor(sqrt(disc))
  localparam int RemW   = RootW + 3;            // square root remainder
  localparam int NumW   = CoefWidth + 2;        // signed -b +/- s
  localparam int NmagW  = CoefWidth + 1;        // magnitude of -b +/- s
  localparam int DvdW   = NmagW + FracBits;     // dividend, scaled
  localparam int DenW   = CoefWidth + 1;        // 2 * |a|
  localparam int TolW   = 32;

  localparam logic [TolW-1:0] TolReset = TolW'(429);

  // Stream widths
  localparam int InDataW  = ((3 * CoefWidth + 7) / 8) * 8;
  localparam int OutDataW = ((2 * CoefWidth + 1 + 7) / 8) * 8;
  localparam int KindW    = 2;

  // Queue between classifier and solver
  localparam int QueueDepth = 4;
  localparam int QueueIdxW  = $clog2(QueueDepth);

  typedef enum logic [KindW-1:0] {
    KIND_TWO    = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_NONE   = 2'd2,
    KIND_AZERO  = 2'd3
  } kind_e;

  // Classified item handed from front to back
  typedef struct packed {
    kind_e             kind;
    logic              a_neg;
    logic [MagW-1:0]   a_mag;
    logic              b_neg;
    logic [MagW-1:0]   b_mag;
    logic [DiscW-1:0]  dmag;
  } job_t;

endpackage

@@ rtl/core/qrs_front.sv @@
`timescale 1ns / 1ps

module qrs_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [qrs_pkg::MagW-1:0]    coef_a_i,
  input  logic [qrs_pkg::MagW-1:0]    coef_b_i,
  input  logic [qrs_pkg::MagW-1:0]    coef_c_i,
  input  logic                        cfg_we_i,
  input  logic [qrs_pkg::TolW-1:0]    cfg_wdata_i,
  input  logic                        space_i,
  output logic                        push_o,
  output qrs_pkg::job_t               job_o
);

  localparam int CW = qrs_pkg::CoefWidth;

  function automatic logic [qrs_pkg::MagW-1:0] mag_of(input logic [CW-1:0] v);
    mag_of = v[CW-1] ? (~v + 1'b1) : v;
  endfunction

  logic                       advance;
  logic [qrs_pkg::TolW-1:0]   tol_q;

  logic                       v1_q;
  logic                       a1_neg_q, b1_neg_q, c1_neg_q;
  logic [qrs_pkg::MagW-1:0]   a1_mag_q, b1_mag_q, c1_mag_q;

  logic                       v2_q;
  logic                       a2_neg_q, b2_neg_q, c2_neg_q;
  logic [qrs_pkg::MagW-1:0]   a2_mag_q, b2_mag_q;
  logic [qrs_pkg::ProdW-1:0]  sq_q, prod_q;

  logic [qrs_pkg::DiscW-1:0]  sqx, prod4, dmag;
  logic                       dneg, over;

  // Whole front moves while the queue has room
  assign advance    = space_i;
  assign in_ready_o = advance;

  // Tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= qrs_pkg::TolReset;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (advance) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  // Stage 1: sign and magnitude split
  always_ff @(posedge clk_i) begin
    if (advance) begin
      a1_neg_q <= coef_a_i[CW-1];
      b1_neg_q <= coef_b_i[CW-1];
      c1_neg_q <= coef_c_i[CW-1];
      a1_mag_q <= mag_of(coef_a_i);
      b1_mag_q <= mag_of(coef_b_i);
      c1_mag_q <= mag_of(coef_c_i);
    end
  end

  // Stage 2: b*b and a*c
  always_ff @(posedge clk_i) begin
    if (advance) begin
      a2_neg_q <= a1_neg_q;
      b2_neg_q <= b1_neg_q;
      c2_neg_q <= c1_neg_q;
      a2_mag_q <= a1_mag_q;
      b2_mag_q <= b1_mag_q;
      sq_q     <= qrs_pkg::ProdW'(b1_mag_q) * qrs_pkg::ProdW'(b1_mag_q);
      prod_q   <= qrs_pkg::ProdW'(a1_mag_q) * qrs_pkg::ProdW'(c1_mag_q);
    end
  end

  // Stage 3: discriminant and classification, written into the queue
  always_comb begin
    sqx   = {1'b0, sq_q};
    prod4 = {prod_q[qrs_pkg::ProdW-2:0], 2'b00};
    if (a2_neg_q != c2_neg_q) begin
      dneg = 1'b0;
      dmag = sqx + prod4;
    end else if (sqx >= prod4) begin
      dneg = 1'b0;
      dmag = sqx - prod4;
    end else begin
      dneg = 1'b1;
      dmag = prod4 - sqx;
    end
    over = dmag > qrs_pkg::DiscW'(tol_q);

    job_o.a_neg = a2_neg_q;
    job_o.a_mag = a2_mag_q;
    job_o.b_neg = b2_neg_q;
    job_o.b_mag = b2_mag_q;
    if (a2_mag_q == '0) begin
      job_o.kind = qrs_pkg::KIND_AZERO;
    end else if (over && dneg) begin
      job_o.kind = qrs_pkg::KIND_NONE;
    end else if (over) begin
      job_o.kind = qrs_pkg::KIND_TWO;
    end else begin
      job_o.kind = qrs_pkg::KIND_DOUBLE;
    end
    // only two distinct roots need the square root
    job_o.dmag = (job_o.kind == qrs_pkg::KIND_TWO) ? dmag : '0;
  end

  assign push_o = v2_q & advance;

endmodule

@@ rtl/core/qrs_queue.sv @@
`timescale 1ns / 1ps

module qrs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  qrs_pkg::job_t  job_i,
  output logic           space_o,
  input  logic           pop_i,
  output logic           valid_o,
  output qrs_pkg::job_t  job_o
);

  localparam int IW = qrs_pkg::QueueIdxW;

  qrs_pkg::job_t   mem_q [qrs_pkg::QueueDepth];
  logic [IW-1:0]   wr_q, rd_q;
  logic [IW:0]     cnt_q;
  logic            do_pop;

  assign space_o = cnt_q != (IW + 1)'(qrs_pkg::QueueDepth);
  assign valid_o = cnt_q != '0;
  assign do_pop  = pop_i & valid_o;
  assign job_o   = mem_q[rd_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/qrs_back.sv @@
`timescale 1ns / 1ps

module qrs_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_valid_i,
  input  qrs_pkg::job_t                  job_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output qrs_pkg::kind_e                 root_kind_o,
  output logic [qrs_pkg::CoefWidth-1:0]  root_one_o,
  output logic [qrs_pkg::CoefWidth-1:0]  root_two_o,
  output logic                           saturated_o
);

  localparam int CW    = qrs_pkg::CoefWidth;
  localparam int RootW = qrs_pkg::RootW;
  localparam int RemW  = qrs_pkg::RemW;
  localparam int DvdW  = qrs_pkg::DvdW;
  localparam int DenW  = qrs_pkg::DenW;
  localparam int NumW  = qrs_pkg::NumW;
  localparam int NmagW = qrs_pkg::NmagW;

  localparam logic [DvdW-1:0] LimPos = (DvdW'(1) << (CW - 1)) - DvdW'(1);
  localparam logic [DvdW-1:0] LimNeg = DvdW'(1) << (CW - 1);
  localparam logic [CW-1:0]   MaxVal = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0]   MinVal = {1'b1, {(CW - 1){1'b0}}};

  typedef struct packed {
    qrs_pkg::kind_e              kind;
    logic                        a_neg;
    logic [qrs_pkg::MagW-1:0]    a_mag;
    logic                        b_neg;
    logic [qrs_pkg::MagW-1:0]    b_mag;
    logic [RemW-1:0]             rem;
    logic [RootW-1:0]            root;
    logic [2*RootW-1:0]          dbits;
  } sq_t;

  typedef struct packed {
    logic [DenW-1:0]  rem;
    logic [DvdW-1:0]  q;
    logic [DvdW-1:0]  dv;
  } lane_t;

  typedef struct packed {
    qrs_pkg::kind_e   kind;
    logic             neg1;
    logic             neg2;
    logic [DenW-1:0]  den;
    lane_t            l1;
    lane_t            l2;
  } dv_t;

  // One restoring division step
  function automatic lane_t div_step(input lane_t l, input logic [DenW-1:0] den);
    logic [DenW:0] remx;
    lane_t         r;
    remx = {l.rem, l.dv[DvdW-1]};
    r.dv = {l.dv[DvdW-2:0], 1'b0};
    if (remx >= {1'b0, den}) begin
      remx = remx - {1'b0, den};
      r.q  = {l.q[DvdW-2:0], 1'b1};
    end else begin
      r.q  = {l.q[DvdW-2:0], 1'b0};
    end
    r.rem = remx[DenW-1:0];
    return r;
  endfunction

  function automatic logic [NmagW-1:0] nmag_of(input logic [NumW-1:0] n);
    logic [NumW-1:0] m;
    m = n[NumW-1] ? (~n + 1'b1) : n;
    return m[NmagW-1:0];
  endfunction

  logic advance;

  // Whole back moves while the output register is free or being taken
  assign advance = !out_valid_o || out_ready_i;
  assign pop_o   = advance & job_valid_i;

  // ---------------- square root pipeline, one root bit per stage
  sq_t   sq_in [RootW];
  sq_t   sq_q  [RootW];
  logic  sv_in [RootW];
  logic  sv_q  [RootW];

  assign sq_in[0] = '{
    kind:  job_i.kind,
    a_neg: job_i.a_neg,
    a_mag: job_i.a_mag,
    b_neg: job_i.b_neg,
    b_mag: job_i.b_mag,
    rem:   '0,
    root:  '0,
    dbits: (2 * RootW)'(job_i.dmag)
  };
  assign sv_in[0] = pop_o;

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    sq_t             nxt;
    logic [RemW-1:0] remx, trial;

    if (k > 0) begin : g_link
      assign sq_in[k] = sq_q[k-1];
      assign sv_in[k] = sv_q[k-1];
    end

    always_comb begin
      nxt   = sq_in[k];
      remx  = {sq_in[k].rem[RemW-3:0], sq_in[k].dbits[2*RootW-1 -: 2]};
      trial = RemW'({sq_in[k].root, 2'b01});
      if (remx >= trial) begin
        nxt.rem  = remx - trial;
        nxt.root = {sq_in[k].root[RootW-2:0], 1'b1};
      end else begin
        nxt.rem  = remx;
        nxt.root = {sq_in[k].root[RootW-2:0], 1'b0};
      end
      nxt.dbits = {sq_in[k].dbits[2*RootW-3:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else if (advance) begin
        sv_q[k] <= sv_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        sq_q[k] <= nxt;
      end
    end
  end

  // ---------------- numerators -b + s and -b - s
  logic [RootW-1:0] s_val;
  logic [NumW-1:0]  bpos, nb, n1, n2;
  dv_t              nm_q;
  logic             nv_q;

  always_comb begin
    s_val = (sq_q[RootW-1].kind == qrs_pkg::KIND_TWO) ? sq_q[RootW-1].root : '0;
    bpos  = NumW'(sq_q[RootW-1].b_mag);
    nb    = sq_q[RootW-1].b_neg ? bpos : (~bpos + 1'b1);
    n1    = nb + NumW'(s_val);
    n2    = nb - NumW'(s_val);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
    end else if (advance) begin
      nv_q <= sv_q[RootW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      nm_q.kind  <= sq_q[RootW-1].kind;
      nm_q.neg1  <= n1[NumW-1] ^ sq_q[RootW-1].a_neg;
      nm_q.neg2  <= n2[NumW-1] ^ sq_q[RootW-1].a_neg;
      nm_q.den   <= {sq_q[RootW-1].a_mag, 1'b0};
      nm_q.l1.rem <= '0;
      nm_q.l1.q   <= '0;
      nm_q.l1.dv  <= {nmag_of(n1), {qrs_pkg::FracBits{1'b0}}};
      nm_q.l2.rem <= '0;
      nm_q.l2.q   <= '0;
      nm_q.l2.dv  <= {nmag_of(n2), {qrs_pkg::FracBits{1'b0}}};
    end
  end

  // ---------------- two dividers by 2|a|, one quotient bit per stage
  dv_t   dv_in [DvdW];
  dv_t   dv_q  [DvdW];
  logic  dvv_in [DvdW];
  logic  dvv_q  [DvdW];

  assign dv_in[0]  = nm_q;
  assign dvv_in[0] = nv_q;

  for (genvar k = 0; k < DvdW; k++) begin : g_div
    dv_t nxt;

    if (k > 0) begin : g_link
      assign dv_in[k]  = dv_q[k-1];
      assign dvv_in[k] = dvv_q[k-1];
    end

    always_comb begin
      nxt    = dv_in[k];
      nxt.l1 = div_step(dv_in[k].l1, dv_in[k].den);
      nxt.l2 = div_step(dv_in[k].l2, dv_in[k].den);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[k] <= 1'b0;
      end else if (advance) begin
        dvv_q[k] <= dvv_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        dv_q[k] <= nxt;
      end
    end
  end

  // ---------------- clamp, sign and output register
  dv_t              fin;
  logic [DvdW-1:0]  lim1, lim2, qv1, qv2;
  logic             sat1, sat2;
  logic [CW-1:0]    r1, r2;

  assign fin = dv_q[DvdW-1];

  always_comb begin
    lim1 = fin.neg1 ? LimNeg : LimPos;
    lim2 = fin.neg2 ? LimNeg : LimPos;
    sat1 = fin.l1.q > lim1;
    sat2 = fin.l2.q > lim2;
    qv1  = sat1 ? lim1 : fin.l1.q;
    qv2  = sat2 ? lim2 : fin.l2.q;
    r1   = fin.neg1 ? (~qv1[CW-1:0] + 1'b1) : qv1[CW-1:0];
    r2   = fin.neg2 ? (~qv2[CW-1:0] + 1'b1) : qv2[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= dvv_q[DvdW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      root_kind_o <= fin.kind;
      case (fin.kind)
        qrs_pkg::KIND_TWO: begin
          root_one_o  <= r1;
          root_two_o  <= r2;
          saturated_o <= sat1 | sat2;
        end
        qrs_pkg::KIND_DOUBLE: begin
          root_one_o  <= r1;
          root_two_o  <= r1;
          saturated_o <= sat1;
        end
        default: begin
          root_one_o  <= '0;
          root_two_o  <= '0;
          saturated_o <= 1'b0;
        end
      endcase
    end
  end

  // No root reported when there is none
  a_no_roots_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (root_kind_o == qrs_pkg::KIND_NONE || root_kind_o == qrs_pkg::KIND_AZERO)
    |-> root_one_o == '0 && root_two_o == '0 && !saturated_o)
    else $error("roots present without real roots");

  // A double root gives the same value twice
  a_double_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_kind_o == qrs_pkg::KIND_DOUBLE |-> root_one_o == root_two_o)
    else $error("double root mismatch");

  // A clamped result sits at an end of the range
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o
    |-> root_one_o == MaxVal || root_one_o == MinVal
        || root_two_o == MaxVal || root_two_o == MinVal)
    else $error("saturation flag without clamped root");

endmodule

@@ rtl/core/quadratic_root_solver_unit.sv @@
// Items pass the front stages, queue, square root pipeline (one root bit per stage),
// numerator register, dividers by 2a (one quotient bit per stage) and output register.
// Throughput: one item per cycle while the output is not stalled.
// A four-item queue decouples the classifier from the solver; each side stalls alone.
// Reset (async, active low) empties the pipelines and queue and loads tolerance 429.
`timescale 1ns / 1ps

module quadratic_root_solver_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [31:0] coef_a, [63:32] coef_b, [95:64] coef_c
  input  logic [qrs_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] root_one, [63:32] root_two, [64] saturated, rest zero
  output logic [qrs_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // [1:0] root_kind
  output logic [qrs_pkg::KindW-1:0]     m_axis_tuser_o,
  input  logic                          cfg_we_i,
  input  logic [qrs_pkg::TolW-1:0]      cfg_wdata_i
);

  localparam int CW = qrs_pkg::CoefWidth;

  logic            push, space, job_valid, pop;
  qrs_pkg::job_t   job_in, job_out;
  qrs_pkg::kind_e  kind;
  logic [CW-1:0]   root_one, root_two;
  logic            saturated;

  // Accept and classify
  qrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .coef_a_i    (s_axis_tdata_i[CW-1:0]),
    .coef_b_i    (s_axis_tdata_i[2*CW-1:CW]),
    .coef_c_i    (s_axis_tdata_i[3*CW-1:2*CW]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .space_i     (space),
    .push_o      (push),
    .job_o       (job_in)
  );

  // Item queue
  qrs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .space_o (space),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  // Square root, division and output
  qrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .root_kind_o (kind),
    .root_one_o  (root_one),
    .root_two_o  (root_two),
    .saturated_o (saturated)
  );

  assign m_axis_tdata_o = qrs_pkg::OutDataW'({saturated, root_two, root_one});
  assign m_axis_tuser_o = kind;

endmodule

@@ test/quadratic_root_solver_unit_test.sv @@
`timescale 1ns / 1ps

module quadratic_root_solver_unit_test;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 120;
  localparam int LongHold      = 300;
  localparam int RandPerPhase  = 330;

  // Expected roots for one coefficient set
  typedef struct {
    qrs_pkg::kind_e kind;
    logic [31:0]    root_one;
    logic [31:0]    root_two;
    logic           saturated;
  } roots_t;

  // Computes the roots of each accepted set and checks results in order
  class root_scoreboard;
    roots_t      roots_q[$];
    logic [31:0] tolerance = qrs_pkg::TolReset;
    int          errors = 0;

    // floor of the square root, d below 2^82
    static function logic [127:0] isqrt(logic [127:0] d);
      logic [127:0] r;
      logic [127:0] cand;
      r = '0;
      for (int i = 40; i >= 0; i--) begin
        cand = r | (128'd1 << i);
        if (cand * cand <= d) r = cand;
      end
      return r;
    endfunction

    // num / (2a), truncated toward zero and clamped to 32-bit signed
    static function logic [31:0] divide_root(longint num, bit a_neg, logic [63:0] a_mag,
                                             inout bit sat);
      bit           n_neg;
      bit           neg;
      logic [63:0]  n_mag;
      logic [127:0] q;
      logic [127:0] limit;
      n_neg = num < 0;
      n_mag = n_neg ? 64'(-num) : 64'(num);
      q = (128'(n_mag) << qrs_pkg::FracBits) / (128'(a_mag) << 1);
      neg = n_neg != a_neg;
      limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > limit) begin
        q = limit;
        sat = 1'b1;
      end
      return neg ? 32'(-q) : 32'(q);
    endfunction

    static function logic [63:0] magnitude(logic [31:0] v);
      return v[31] ? 64'd0 - {{32{v[31]}}, v} : {32'd0, v};
    endfunction

    function void note_item(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      logic [63:0]  am;
      logic [63:0]  bm;
      logic [63:0]  cm;
      logic [127:0] sq;
      logic [127:0] pr;
      logic [127:0] dm;
      logic [127:0] s;
      bit           d_neg;
      longint       bv;
      roots_t       r;
      am = magnitude(a);
      bm = magnitude(b);
      cm = magnitude(c);
      r.root_one = '0;
      r.root_two = '0;
      r.saturated = 1'b0;
      if (am == 0) begin
        r.kind = qrs_pkg::KIND_AZERO;
      end else begin
        sq = 128'(bm) * 128'(bm);
        pr = (128'(am) * 128'(cm)) << 2;
        d_neg = 1'b0;
        if (a[31] != c[31]) begin
          dm = sq + pr;
        end else if (sq >= pr) begin
          dm = sq - pr;
        end else begin
          d_neg = 1'b1;
          dm = pr - sq;
        end
        bv = b[31] ? -longint'(bm) : longint'(bm);
        if (dm > 128'(tolerance) && d_neg) begin
          r.kind = qrs_pkg::KIND_NONE;
        end else if (dm > 128'(tolerance)) begin
          s = isqrt(dm);
          r.kind = qrs_pkg::KIND_TWO;
          r.root_one = divide_root(-bv + longint'(s), a[31], am, r.saturated);
          r.root_two = divide_root(-bv - longint'(s), a[31], am, r.saturated);
        end else begin
          r.kind = qrs_pkg::KIND_DOUBLE;
          r.root_one = divide_root(-bv, a[31], am, r.saturated);
          r.root_two = r.root_one;
        end
      end
      roots_q.push_back(r);
    endfunction

    function void check_result(logic [qrs_pkg::KindW-1:0] kind,
                               logic [qrs_pkg::OutDataW-1:0] data);
      roots_t e;
      if (roots_q.size() == 0) begin
        $error("unexpected result: kind %0d data %h", kind, data);
        errors++;
        return;
      end
      e = roots_q.pop_front();
      if (kind !== e.kind) begin
        $error("root_kind: expected %0d, actual %0d", e.kind, kind);
        errors++;
      end
      if (data[31:0] !== e.root_one) begin
        $error("root_one: expected %h, actual %h", e.root_one, data[31:0]);
        errors++;
      end
      if (data[63:32] !== e.root_two) begin
        $error("root_two: expected %h, actual %h", e.root_two, data[63:32]);
        errors++;
      end
      if (data[64] !== e.saturated) begin
        $error("saturated: expected %0d, actual %0d", e.saturated, data[64]);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_valid = 1'b0;
  logic                         s_ready;
  logic [qrs_pkg::InDataW-1:0]  s_data = '0;
  logic                         m_valid;
  logic                         m_ready = 1'b0;
  logic [qrs_pkg::OutDataW-1:0] m_data;
  logic [qrs_pkg::KindW-1:0]    m_user;
  logic                         cfg_we = 1'b0;
  logic [qrs_pkg::TolW-1:0]     cfg_wdata = '0;

  root_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int stall_cycles = 0;

  quadratic_root_solver_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Monitors: both handshakes, sampled at the edge
  always @(posedge clk_i) begin
    if (s_valid && s_ready) sb.note_item(s_data[31:0], s_data[63:32], s_data[95:64]);
    if (m_valid && m_ready) sb.check_result(m_user, m_data);
  end

  // Watchdog on cycles without either handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        m_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic push_item(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic ready_seen;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {c, b, a};
    forever begin
      @(negedge clk_i);
      ready_seen = s_ready;
      @(posedge clk_i);
      if (ready_seen) break;
    end
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.roots_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [31:0] tol);
    cfg_we <= 1'b1;
    cfg_wdata <= tol;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.tolerance = tol;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coef();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(0, 31);
      2: v = $urandom_range(0, 20) << qrs_pkg::FracBits;
      3: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0;
          1: v = 32'h1;
          2: v = 32'h7FFF_FFFF;
          3: v = 32'h8000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = $urandom_range(1, 4000);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // Set near a perfect square: b*b close to 4ac
  task automatic push_near_double();
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    int          k;
    a = $urandom_range(1, 2000);
    k = $urandom_range(0, 30);
    b = 2 * a * k;
    c = a * k * k + $urandom_range(0, 2) - 1;
    if ($urandom_range(0, 1)) begin
      a = -a;
      c = -c;
    end
    if ($urandom_range(0, 1)) b = -b;
    push_item(a, b, c);
  endtask

  initial begin
    logic [31:0] tols [5];
    tols = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'd429, 32'h0};
    tols[2] = $urandom;
    tols[4] = $urandom_range(0, 5000);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero leading term, extremes, each root kind, clamping
    push_item(32'h0, 32'h0001_0000, 32'h0001_0000);
    push_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    push_item(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    push_item(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    push_item(32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000);
    push_item(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
    push_item(32'hFFFF_0000, 32'h0003_0000, 32'hFFFE_0000);
    push_item(32'h1, 32'h0, 32'hFFFF_FFFF);
    push_item(32'h1, 32'h0, 32'h1);
    push_item(32'h1, 32'h0, 32'hFFFF_FF38);
    push_item(32'h1, 32'h0, 32'h0000_00C8);
    push_item(32'h1, 32'h7FFF_FFFF, 32'h0);
    push_item(32'hFFFF_FFFF, 32'h8000_0000, 32'h1);
    push_item(32'h1, 32'h0, 32'h0);
    push_item(32'h0, 32'h0, 32'h0);
    push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    // Random phases over several tolerance settings
    for (int p = 0; p < 5; p++) begin
      write_tolerance(tols[p]);
      if (p == 4) idle_on = 1'b0;
      for (int i = 0; i < RandPerPhase; i++) begin
        if (p == 1 && i == 40) hold_req = 1'b1;
        if ($urandom_range(0, 3) == 0) push_near_double();
        else push_item(pick_coef(), pick_coef(), pick_coef());
      end
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
